/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level of the grammar lexer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// The expression must never be true outside reset.
`define BGL_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lexer assertion failed");

`endif

/* rtl/bgl_pkg.sv */
// Shared types and constants of the grammar lexer.
package bgl_pkg;

  // Token kinds carried on every result transaction.
  localparam logic [3:0] KIND_END      = 4'd0;
  localparam logic [3:0] KIND_SYMBOL   = 4'd1;
  localparam logic [3:0] KIND_TERMINAL = 4'd2;
  localparam logic [3:0] KIND_ELLIPSIS = 4'd3;
  localparam logic [3:0] KIND_HEX      = 4'd4;
  localparam logic [3:0] KIND_LBRACE   = 4'd5;
  localparam logic [3:0] KIND_RBRACE   = 4'd6;
  localparam logic [3:0] KIND_LBRACKET = 4'd7;
  localparam logic [3:0] KIND_RBRACKET = 4'd8;
  localparam logic [3:0] KIND_LPAREN   = 4'd9;
  localparam logic [3:0] KIND_RPAREN   = 4'd10;
  localparam logic [3:0] KIND_CARET    = 4'd11;
  localparam logic [3:0] KIND_BAR      = 4'd12;
  localparam logic [3:0] KIND_WORD     = 4'd13;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Most results a single input item can cause.
  localparam int MAX_RESULTS = 6;

  // Entries in the queue between the front end and the sequencer.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef logic [Q_AW-1:0] q_ptr_t;
  typedef logic [Q_AW:0]   q_count_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SYMBOL,
    MODE_TERMINAL,
    MODE_DOT1,
    MODE_DOT2,
    MODE_ZERO,
    MODE_HEX,
    MODE_WORD
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_last;
    logic       last_of_run;
  } out_item_t;

  // Character class flags worked out by the front end.
  typedef struct packed {
    logic       space_tab;
    logic       ws_other;
    logic       lt;
    logic       gt;
    logic       squote;
    logic       dquote;
    logic       dot;
    logic       zero;
    logic       x_letter;
    logic       hex_digit;
    logic [3:0] punct;
  } char_class_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        end_of_input;
    char_class_t cls;
  } q_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* rtl/bnf_grammar_lexer.sv */
// Grammar text lexer top level: front end, queue and token sequencer.
//
// The lexer takes grammar text one byte per input transaction and returns each
// token as a run of value-character transactions closed by an end-marker
// transaction that carries the token kind (symbols in angle brackets, quoted
// terminals, the three-dot ellipsis, 0x hex literals, the eight punctuators
// and plain words); an end_of_input transaction closes any open token and
// yields an END token, after which a new text may follow. Input bytes are
// classified in a front register and placed in a four-entry queue; the
// sequencer behind it takes one queued character per cycle while no earlier
// burst is left to play out, computes its whole burst of zero to six
// results at once, and plays that burst out through the output register
// one result per cycle unless the output is stalled. It takes the next
// character as the final result of the current burst moves out; typical
// text gives one or two results per byte. An accepted input passes the
// front register, the queue, the burst store and the output register before
// its first result appears. The input side keeps accepting while results
// wait on a stalled output until the queue and front register are full.
module bnf_grammar_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bgl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bgl_pkg::out_item_t out_data
);
  import bgl_pkg::*;

  `include "assert_macros.svh"

  logic      push;
  q_item_t   push_data;
  logic      pop;
  q_item_t   head;
  q_status_t q_stat;

  bgl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  bgl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  bgl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A result without a character is always the marker that closes a token.
  `BGL_ASSERT_IMP(a_marker_closes, out_valid && !out_data.has_char, out_data.token_last)
  // The END token is a bare marker and always ends its transaction burst.
  `BGL_ASSERT_IMP(a_end_last, out_valid && (out_data.token_kind == KIND_END),
                  !out_data.has_char && out_data.last_of_run)
  // The queue cannot report empty and full together.
  `BGL_ASSERT_NEVER(a_queue_status, q_stat.empty && q_stat.full)

endmodule

/* rtl/bgl_front.sv */
// Input stage: accepts text characters and classifies them into a register.
module bgl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bgl_pkg::in_item_t  in_data,
  input  bgl_pkg::q_status_t q_stat,
  output logic               push,
  output bgl_pkg::q_item_t   push_data
);
  import bgl_pkg::*;

  logic        hold_valid;
  q_item_t     hold;
  char_class_t cls_next;

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h7B:   punct_kind = KIND_LBRACE;
      8'h7D:   punct_kind = KIND_RBRACE;
      8'h5B:   punct_kind = KIND_LBRACKET;
      8'h5D:   punct_kind = KIND_RBRACKET;
      8'h28:   punct_kind = KIND_LPAREN;
      8'h29:   punct_kind = KIND_RPAREN;
      8'h5E:   punct_kind = KIND_CARET;
      8'h7C:   punct_kind = KIND_BAR;
      default: punct_kind = KIND_END;
    endcase
  endfunction

  always_comb begin
    cls_next.space_tab = (in_data.char_code == 8'h20) || (in_data.char_code == 8'h09);
    cls_next.ws_other  = in_data.char_code inside {[8'h0A:8'h0D]};
    cls_next.lt        = in_data.char_code == 8'h3C;
    cls_next.gt        = in_data.char_code == 8'h3E;
    cls_next.squote    = in_data.char_code == 8'h27;
    cls_next.dquote    = in_data.char_code == 8'h22;
    cls_next.dot       = in_data.char_code == CH_DOT;
    cls_next.zero      = in_data.char_code == CH_ZERO;
    cls_next.x_letter  = (in_data.char_code == 8'h78) || (in_data.char_code == 8'h58);
    cls_next.hex_digit = in_data.char_code inside {[8'h30:8'h39], [8'h61:8'h66],
                                                   [8'h41:8'h46]};
    cls_next.punct     = punct_kind(in_data.char_code);
  end

  assign push      = hold_valid && !q_stat.full;
  assign in_stall  = hold_valid && q_stat.full;
  assign push_data = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold.char_code    <= in_data.char_code;
      hold.end_of_input <= in_data.end_of_input;
      hold.cls          <= cls_next;
    end
  end

endmodule

/* rtl/bgl_queue.sv */
// Four-entry queue between the classifying front end and the token sequencer.
module bgl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bgl_pkg::q_item_t   push_data,
  input  logic               pop,
  output bgl_pkg::q_item_t   head,
  output bgl_pkg::q_status_t stat
);
  import bgl_pkg::*;

  q_item_t  mem [Q_DEPTH];
  q_ptr_t   wr_ptr;
  q_ptr_t   rd_ptr;
  q_count_t count;

  assign head       = mem[rd_ptr];
  assign stat.empty = count == '0;
  assign stat.full  = count == q_count_t'(Q_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + q_ptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + q_ptr_t'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + q_count_t'(1);
        2'b01:   count <= count - q_count_t'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/bgl_back.sv */
// Token sequencer: turns one classified character into its burst of results.
module bgl_back (
  input  logic                clk,
  input  logic                rst,
  input  bgl_pkg::q_item_t    head,
  input  bgl_pkg::q_status_t  q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bgl_pkg::out_item_t  out_data
);
  import bgl_pkg::*;

  scan_mode_t  mode;
  scan_mode_t  mode_next;
  logic        dq;
  logic        dq_next;
  logic        use_ts;
  out_item_t   burst [MAX_RESULTS];
  logic [2:0]  rem;
  logic [2:0]  idx;
  logic        move;

  out_item_t   pre [4];
  logic [2:0]  pn;
  out_item_t   tl [2];
  logic [1:0]  tn;
  out_item_t   res [MAX_RESULTS];
  logic [2:0]  n;

  out_item_t   ts_it [2];
  logic [1:0]  ts_n;
  scan_mode_t  ts_mode;
  logic        stops;
  char_class_t cl;
  logic [7:0]  c;

  function automatic out_item_t mk(input logic [3:0] kind, input logic [7:0] ch,
                                   input logic has, input logic last);
    out_item_t r;
    r.token_kind  = kind;
    r.char_value  = ch;
    r.has_char    = has;
    r.token_last  = last;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign cl    = head.cls;
  assign c     = head.char_code;
  assign stops = cl.space_tab || cl.ws_other || (cl.punct != KIND_END) || cl.dot;

  // What a character does when it opens a new token.
  always_comb begin
    ts_it[0] = mk(KIND_WORD, c, 1'b1, 1'b0);
    ts_it[1] = mk(KIND_WORD, 8'h00, 1'b0, 1'b1);
    ts_n     = 2'd0;
    ts_mode  = MODE_IDLE;
    if (cl.space_tab) begin
      ts_n = 2'd0;
    end else if (cl.lt) begin
      ts_it[0] = mk(KIND_SYMBOL, c, 1'b1, 1'b0);
      ts_n     = 2'd1;
      ts_mode  = MODE_SYMBOL;
    end else if (cl.squote || cl.dquote) begin
      ts_mode = MODE_TERMINAL;
    end else if (cl.dot) begin
      ts_mode = MODE_DOT1;
    end else if (cl.zero) begin
      ts_mode = MODE_ZERO;
    end else if (cl.punct != KIND_END) begin
      ts_it[0] = mk(cl.punct, c, 1'b1, 1'b0);
      ts_it[1] = mk(cl.punct, 8'h00, 1'b0, 1'b1);
      ts_n     = 2'd2;
    end else if (cl.ws_other) begin
      ts_n = 2'd2;
    end else begin
      ts_n    = 2'd1;
      ts_mode = MODE_WORD;
    end
  end

  // Next scan mode, and whether the character also opens a new token.
  always_comb begin
    use_ts    = 1'b0;
    mode_next = mode;
    dq_next   = dq;
    if (head.end_of_input) begin
      mode_next = MODE_IDLE;
      dq_next   = 1'b0;
    end else begin
      case (mode)
        MODE_SYMBOL: begin
          if (cl.gt) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_TERMINAL: begin
          if ((dq && cl.dquote) || (!dq && cl.squote)) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_DOT1: begin
          if (cl.dot) begin
            mode_next = MODE_DOT2;
          end else begin
            use_ts = 1'b1;
          end
        end
        MODE_DOT2: begin
          if (cl.dot) begin
            mode_next = MODE_IDLE;
          end else begin
            use_ts = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (cl.x_letter) begin
            mode_next = MODE_HEX;
          end else if (stops) begin
            use_ts = 1'b1;
          end else begin
            mode_next = MODE_WORD;
          end
        end
        MODE_HEX: begin
          if (!cl.hex_digit) begin
            use_ts = 1'b1;
          end
        end
        MODE_WORD: begin
          if (stops) begin
            use_ts = 1'b1;
          end
        end
        default: use_ts = 1'b1;
      endcase
      if (use_ts) begin
        mode_next = ts_mode;
        if (cl.squote || cl.dquote) begin
          dq_next = cl.dquote;
        end
      end
    end
  end

  // Results owed to the current mode, then the tail from a token start or END.
  always_comb begin
    pre[0]    = mk(KIND_WORD, CH_DOT, 1'b1, 1'b0);
    pre[1]    = mk(KIND_WORD, 8'h00, 1'b0, 1'b1);
    pre[2]    = mk(KIND_WORD, CH_DOT, 1'b1, 1'b0);
    pre[3]    = mk(KIND_WORD, 8'h00, 1'b0, 1'b1);
    pn        = 3'd0;
    tl[0]     = mk(KIND_END, 8'h00, 1'b0, 1'b1);
    tl[1]     = mk(KIND_END, 8'h00, 1'b0, 1'b1);
    tn        = 2'd0;
    if (head.end_of_input) begin
      case (mode)
        MODE_SYMBOL: begin
          pre[0] = mk(KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
          pn     = 3'd1;
        end
        MODE_TERMINAL: begin
          pre[0] = mk(KIND_TERMINAL, 8'h00, 1'b0, 1'b1);
          pn     = 3'd1;
        end
        MODE_DOT1: pn = 3'd2;
        MODE_DOT2: pn = 3'd4;
        MODE_ZERO: begin
          pre[0] = mk(KIND_WORD, CH_ZERO, 1'b1, 1'b0);
          pn     = 3'd2;
        end
        MODE_HEX: begin
          pre[0] = mk(KIND_HEX, 8'h00, 1'b0, 1'b1);
          pn     = 3'd1;
        end
        MODE_WORD: begin
          pre[0] = mk(KIND_WORD, 8'h00, 1'b0, 1'b1);
          pn     = 3'd1;
        end
        default: pn = 3'd0;
      endcase
      tn = 2'd1;
    end else begin
      case (mode)
        MODE_SYMBOL: begin
          pre[0] = mk(KIND_SYMBOL, c, 1'b1, 1'b0);
          pre[1] = mk(KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
          if (cl.gt) begin
            pn = 3'd2;
          end else begin
            pn = 3'd1;
          end
        end
        MODE_TERMINAL: begin
          if ((dq && cl.dquote) || (!dq && cl.squote)) begin
            pre[0] = mk(KIND_TERMINAL, 8'h00, 1'b0, 1'b1);
          end else begin
            pre[0] = mk(KIND_TERMINAL, c, 1'b1, 1'b0);
          end
          pn = 3'd1;
        end
        MODE_DOT1: begin
          if (!cl.dot) begin
            pn = 3'd2;
          end
        end
        MODE_DOT2: begin
          if (cl.dot) begin
            pre[0] = mk(KIND_ELLIPSIS, CH_DOT, 1'b1, 1'b0);
            pre[1] = mk(KIND_ELLIPSIS, CH_DOT, 1'b1, 1'b0);
            pre[2] = mk(KIND_ELLIPSIS, CH_DOT, 1'b1, 1'b0);
            pre[3] = mk(KIND_ELLIPSIS, 8'h00, 1'b0, 1'b1);
          end
          pn = 3'd4;
        end
        MODE_ZERO: begin
          if (cl.x_letter) begin
            pre[0] = mk(KIND_HEX, CH_ZERO, 1'b1, 1'b0);
            pre[1] = mk(KIND_HEX, c, 1'b1, 1'b0);
          end else begin
            pre[0] = mk(KIND_WORD, CH_ZERO, 1'b1, 1'b0);
            if (!stops) begin
              pre[1] = mk(KIND_WORD, c, 1'b1, 1'b0);
            end
          end
          pn = 3'd2;
        end
        MODE_HEX: begin
          if (cl.hex_digit) begin
            pre[0] = mk(KIND_HEX, c, 1'b1, 1'b0);
          end else begin
            pre[0] = mk(KIND_HEX, 8'h00, 1'b0, 1'b1);
          end
          pn = 3'd1;
        end
        MODE_WORD: begin
          if (stops) begin
            pre[0] = mk(KIND_WORD, 8'h00, 1'b0, 1'b1);
          end else begin
            pre[0] = mk(KIND_WORD, c, 1'b1, 1'b0);
          end
          pn = 3'd1;
        end
        default: pn = 3'd0;
      endcase
      if (use_ts) begin
        tl[0] = ts_it[0];
        tl[1] = ts_it[1];
        tn    = ts_n;
      end
    end
  end

  // Join the two parts and flag the final result of the burst.
  always_comb begin
    logic [2:0] j;
    n = pn + {1'b0, tn};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      j = 3'(i) - pn;
      if (3'(i) < pn) begin
        res[i] = pre[i[1:0]];
      end else begin
        res[i] = tl[j[0]];
      end
      res[i].last_of_run = (3'(i) == n - 3'd1);
    end
  end

  assign move = (rem != 3'd0) && (!out_valid || !out_stall);
  assign pop  = !q_stat.empty && ((rem == 3'd0) || ((rem == 3'd1) && move));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      dq        <= 1'b0;
      rem       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode <= mode_next;
        dq   <= dq_next;
        rem  <= n;
        idx  <= '0;
      end else if (move) begin
        rem <= rem - 3'd1;
        idx <= idx + 3'd1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        burst[i] <= res[i];
      end
    end
    if (move) begin
      out_data <= burst[idx];
    end
  end

endmodule
